@@ sv/assert_macros.svh @@
// assertion macros for the colour sensor conversion checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CSCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cscc assertion failed");

// clocked assertion that also holds through reset
`define CSCC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cscc assertion failed");

`endif

@@ sv/cscc_pkg.sv @@
// constants, coefficient table and decode functions for the colour sensor conversion
package cscc_pkg;

  localparam int RAW_W           = 32;
  localparam int CHROMA_W        = 16;
  localparam int LUX_W           = 36;
  localparam int N_CH            = 4;
  localparam int N_TERMS         = 16;
  localparam int TERM_IDX_W      = 4;
  localparam int CNT_W           = $clog2(N_TERMS + 1);

  localparam int COEF_FRAC_BITS  = 32;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int TABLE_FRAC_BITS = 40;
  localparam int TABLE_W         = 40;

  localparam int MANT_W          = 20;
  localparam int EXP_W           = 4;
  localparam int SCNT_W          = 4;
  localparam int LIN_W           = MANT_W + (1 << EXP_W) - 1;
  localparam int COEF_W          = COEF_FRAC_BITS - 7;
  localparam int PROD_W          = LIN_W + COEF_W;
  localparam int ACC_W           = PROD_W + 3;
  localparam int SUM_W           = ACC_W + 2;
  localparam int STEP_W          = $clog2(RATIO_FRAC_BITS + 1);
  localparam int QX_W            = (RATIO_FRAC_BITS > CHROMA_W) ? RATIO_FRAC_BITS : CHROMA_W;
  localparam int LUX_SH          = COEF_FRAC_BITS - 8;
  localparam int LUX_TW          = ACC_W + 1;
  localparam int COEF_SH         = TABLE_FRAC_BITS - COEF_FRAC_BITS;
  localparam int COEF_RND        = (COEF_SH > 0) ? COEF_SH - 1 : 0;

  localparam logic [LUX_W-1:0]    LUX_MAX    = '1;
  localparam logic [CHROMA_W-1:0] CHROMA_MAX = '1;

  // magnitudes at 40 fraction bits, entry = channel * 4 + column (X, Y, Z, lux)
  localparam logic [TABLE_W-1:0] COEF_MAG40 [N_TERMS] = '{
    40'd258267576, 40'd20852501,  40'd13283385,  40'd0,
    40'd44801519,  40'd218756857, 40'd17465535,  40'd2363950000,
    40'd102102783, 40'd18663061,  40'd741094499, 40'd0,
    40'd0,         40'd0,         40'd0,         40'd0
  };

  // sign of each entry, set means negative
  localparam logic [N_TERMS-1:0] COEF_NEG = 16'h0242;

  function automatic logic [COEF_W-1:0] coef_mag(input logic [TERM_IDX_W-1:0] idx);
    logic [TABLE_W:0] r;
    if (COEF_SH > 0) begin
      r = ({1'b0, COEF_MAG40[idx]} + ((TABLE_W + 1)'(1) << COEF_RND)) >> COEF_SH;
    end else begin
      r = {1'b0, COEF_MAG40[idx]};
    end
    return COEF_W'(r);
  endfunction

  function automatic logic [LIN_W-1:0] decode_lin(input logic [RAW_W-1:0] w);
    logic [LIN_W-1:0] m;
    m = LIN_W'(w[27:8]);
    return m << w[31:28];
  endfunction

endpackage

@@ sv/cscc_ifs.sv @@
// input and result channel interfaces of the colour sensor conversion
interface cscc_in_if;
  import cscc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_ch0;
  logic [RAW_W-1:0] raw_ch1;
  logic [RAW_W-1:0] raw_ch2;
  logic [RAW_W-1:0] raw_ch3;
  modport source (output valid, output raw_ch0, output raw_ch1, output raw_ch2,
                  output raw_ch3, input ready);
  modport sink   (input valid, input raw_ch0, input raw_ch1, input raw_ch2,
                  input raw_ch3, output ready);
endinterface

interface cscc_out_if;
  import cscc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHROMA_W-1:0] chroma_x;
  logic [CHROMA_W-1:0] chroma_y;
  logic [CHROMA_W-1:0] chroma_z;
  logic [LUX_W-1:0]    lux_q8;
  logic                counter_mismatch;
  logic                zero_sum;
  modport source (output valid, output chroma_x, output chroma_y, output chroma_z,
                  output lux_q8, output counter_mismatch, output zero_sum, input ready);
  modport sink   (input valid, input chroma_x, input chroma_y, input chroma_z,
                  input lux_q8, input counter_mismatch, input zero_sum, output ready);
endinterface

@@ sv/color_sensor_cie_conversion.sv @@
// colour sensor conversion to cie chromaticity and lux, serial mac and shared divider
//
//   channel   dir   handshake          payload
//   in_chan   in    valid / ready      raw_ch0..raw_ch3, 32 bits each
//   out_chan  out   valid / ready      chroma_x/y/z, lux_q8, counter_mismatch, zero_sum
//
// after acceptance the shared multiplier takes one matrix term a cycle, then drains;
// the shared restoring divider then works out the three ratios in turn, and last
// the result register is loaded; decode happens at acceptance
// in_ready is high only while idle; a waiting result does not block the next
// transaction until that one reaches its own result load
// synchronous active-low reset clears the sequencer, result valid and sample counter
module color_sensor_cie_conversion (
  input  logic       clk,
  input  logic       rst_n,
  cscc_in_if.sink    in_chan,
  cscc_out_if.source out_chan
);
  import cscc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_FIN} state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SCNT_W-1:0]           exp_cnt_r, exp_cnt_nxt;
  logic [LIN_W-1:0]            lin_r [N_CH];
  logic [LIN_W-1:0]            lin_nxt [N_CH];
  logic                        mismatch_r, mismatch_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic                        pneg_r, pneg_nxt;
  logic [1:0]                  pj_r, pj_nxt;
  logic signed [ACC_W-1:0]     acc_r [4];
  logic signed [ACC_W-1:0]     acc_nxt [4];
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [1:0]                  comp_r, comp_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [SUM_W-1:0]            rem_r, rem_nxt;
  logic [RATIO_FRAC_BITS-1:0]  q_r, q_nxt;
  logic                        szero_r, szero_nxt;
  logic                        sones_r, sones_nxt;
  logic [RATIO_FRAC_BITS-1:0]  ratio_r [3];
  logic [RATIO_FRAC_BITS-1:0]  ratio_nxt [3];

  logic                        out_valid_r, out_valid_nxt;
  logic [CHROMA_W-1:0]         chroma_r [3];
  logic [CHROMA_W-1:0]         chroma_nxt [3];
  logic [LUX_W-1:0]            lux_r, lux_nxt;
  logic                        omis_r, omis_nxt;
  logic                        ozero_r, ozero_nxt;

  logic [RAW_W-1:0]            raw [N_CH];
  logic [SCNT_W-1:0]           exp_step;
  logic signed [ACC_W-1:0]     term;
  logic [ACC_W-1:0]            term_u;
  logic signed [SUM_W-1:0]     v;
  logic [SUM_W-1:0]            sh;
  logic [SUM_W-1:0]            sum_u;
  logic                        ge;
  logic [RATIO_FRAC_BITS-1:0]  qn;
  logic [RATIO_FRAC_BITS-1:0]  res;
  logic [LUX_TW-1:0]           lux_t;
  logic [LUX_TW-1:0]           lux_s;
  logic [QX_W-1:0]             qx;
  logic                        zsum;
  logic                        in_acc;

  assign raw[0]   = in_chan.raw_ch0;
  assign raw[1]   = in_chan.raw_ch1;
  assign raw[2]   = in_chan.raw_ch2;
  assign raw[3]   = in_chan.raw_ch3;
  assign exp_step = exp_cnt_r + SCNT_W'(1);
  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign sum_u    = unsigned'(sum_r);

  assign term_u = ACC_W'(prod_r);
  assign term   = pneg_r ? signed'(ACC_W'(~term_u + ACC_W'(1))) : signed'(term_u);

  always_comb begin
    case (comp_r)
      2'd0:    v = SUM_W'(acc_r[0]);
      2'd1:    v = SUM_W'(acc_r[1]);
      default: v = SUM_W'(acc_r[2]);
    endcase
  end

  assign sh  = {rem_r[SUM_W-2:0], 1'b0};
  assign ge  = (sh >= sum_u);
  assign qn  = {q_r[RATIO_FRAC_BITS-2:0], ge};
  assign res = szero_r ? '0 : (sones_r ? '1 : qn);

  assign zsum  = (sum_r <= 0);
  assign lux_t = LUX_TW'(unsigned'(acc_r[3])) + (LUX_TW'(1) << (LUX_SH - 1));
  assign lux_s = lux_t >> LUX_SH;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    exp_cnt_nxt   = exp_cnt_r;
    lin_nxt       = lin_r;
    mismatch_nxt  = mismatch_r;
    prod_nxt      = prod_r;
    pneg_nxt      = pneg_r;
    pj_nxt        = pj_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    comp_nxt      = comp_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    szero_nxt     = szero_r;
    sones_nxt     = sones_r;
    ratio_nxt     = ratio_r;
    out_valid_nxt = out_valid_r;
    chroma_nxt    = chroma_r;
    lux_nxt       = lux_r;
    omis_nxt      = omis_r;
    ozero_nxt     = ozero_r;
    qx            = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          exp_cnt_nxt  = exp_step;
          mismatch_nxt = 1'b0;
          for (int i = 0; i < N_CH; i++) begin
            lin_nxt[i] = decode_lin(raw[i]);
            if (raw[i][7:4] != exp_step) begin
              mismatch_nxt = 1'b1;
            end
          end
          for (int j = 0; j < 4; j++) begin
            acc_nxt[j] = '0;
          end
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_r < CNT_W'(N_TERMS)) begin
          prod_nxt = {{COEF_W{1'b0}}, lin_r[cnt_r[3:2]]}
                   * {{LIN_W{1'b0}}, coef_mag(cnt_r[TERM_IDX_W-1:0])};
          pneg_nxt = COEF_NEG[cnt_r[TERM_IDX_W-1:0]];
          pj_nxt   = cnt_r[1:0];
        end
        if (cnt_r != '0) begin
          for (int j = 0; j < 4; j++) begin
            if (pj_r == 2'(j)) begin
              acc_nxt[j] = acc_r[j] + term;
            end
          end
          if (pj_r != 2'd3) begin
            sum_nxt = sum_r + SUM_W'(term);
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N_TERMS)) begin
          comp_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          rem_nxt   = unsigned'(v);
          q_nxt     = '0;
          szero_nxt = (v <= 0);
          sones_nxt = (v >= sum_r);
          step_nxt  = STEP_W'(1);
        end else begin
          rem_nxt = ge ? (sh - sum_u) : sh;
          q_nxt   = qn;
          if (step_r == STEP_W'(RATIO_FRAC_BITS)) begin
            for (int i = 0; i < 3; i++) begin
              if (comp_r == 2'(i)) begin
                ratio_nxt[i] = res;
              end
            end
            step_nxt = '0;
            if (comp_r == 2'd2) begin
              state_nxt = ST_FIN;
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          for (int i = 0; i < 3; i++) begin
            qx = QX_W'(ratio_r[i]);
            if (zsum) begin
              chroma_nxt[i] = '0;
            end else if (qx > QX_W'(CHROMA_MAX)) begin
              chroma_nxt[i] = CHROMA_MAX;
            end else begin
              chroma_nxt[i] = qx[CHROMA_W-1:0];
            end
          end
          if (acc_r[3] < 0) begin
            lux_nxt = '0;
          end else if (lux_s > LUX_TW'(LUX_MAX)) begin
            lux_nxt = LUX_MAX;
          end else begin
            lux_nxt = lux_s[LUX_W-1:0];
          end
          omis_nxt      = mismatch_r;
          ozero_nxt     = zsum;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      exp_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
    end
    cnt_r      <= cnt_nxt;
    lin_r      <= lin_nxt;
    mismatch_r <= mismatch_nxt;
    prod_r     <= prod_nxt;
    pneg_r     <= pneg_nxt;
    pj_r       <= pj_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    comp_r     <= comp_nxt;
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    szero_r    <= szero_nxt;
    sones_r    <= sones_nxt;
    ratio_r    <= ratio_nxt;
    chroma_r   <= chroma_nxt;
    lux_r      <= lux_nxt;
    omis_r     <= omis_nxt;
    ozero_r    <= ozero_nxt;
  end

  assign in_chan.ready             = (state_r == ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.chroma_x         = chroma_r[0];
  assign out_chan.chroma_y         = chroma_r[1];
  assign out_chan.chroma_z         = chroma_r[2];
  assign out_chan.lux_q8           = lux_r;
  assign out_chan.counter_mismatch = omis_r;
  assign out_chan.zero_sum         = ozero_r;

endmodule

@@ sv/cscc_checker.sv @@
// port-level checker for the colour sensor conversion and its bind
`include "assert_macros.svh"

module cscc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cscc_pkg::CHROMA_W-1:0] chroma_x,
  input logic [cscc_pkg::CHROMA_W-1:0] chroma_y,
  input logic [cscc_pkg::CHROMA_W-1:0] chroma_z,
  input logic                          zero_sum
);
  import cscc_pkg::*;

  // idle straight after reset
  `CSCC_ASSERT_NR(a_ready_after_rst, clk, !rst_n |=> in_ready)

  // busy once a transaction is taken, and no result appears the next cycle
  `CSCC_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `CSCC_ASSERT(a_no_early_result, clk, rst_n, (in_valid && in_ready) |=> !$rose(out_valid))

  // non-positive sum forces all ratios to zero
  `CSCC_ASSERT(a_zero_sum_ratios, clk, rst_n, (out_valid && zero_sum) |-> (chroma_x == '0 && chroma_y == '0 && chroma_z == '0))

  // stalled result holds: valid stays high, chroma_x and zero_sum stay stable
  `CSCC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(chroma_x) && $stable(zero_sum)))

endmodule

bind color_sensor_cie_conversion cscc_checker u_cscc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .chroma_x  (out_chan.chroma_x),
  .chroma_y  (out_chan.chroma_y),
  .chroma_z  (out_chan.chroma_z),
  .zero_sum  (out_chan.zero_sum)
);

@@ test/tb_color_sensor_cie_conversion.sv @@
`timescale 1ns / 1ps
// self-checking bench for the colour sensor conversion with random handshake timing
module tb_color_sensor_cie_conversion;
  import cscc_pkg::*;

  typedef struct packed {
    logic [N_CH-1:0][RAW_W-1:0] raw;
  } sample_t;

  typedef struct packed {
    logic [CHROMA_W-1:0] chroma_x;
    logic [CHROMA_W-1:0] chroma_y;
    logic [CHROMA_W-1:0] chroma_z;
    logic [LUX_W-1:0]    lux_q8;
    logic                counter_mismatch;
    logic                zero_sum;
  } reading_t;

  localparam int RAND_ITEMS = 650;
  localparam int END_DRAIN  = 100;
  localparam int COEF_DROP  = 40 - COEF_FRAC_BITS;

  // row = channel, column = X, Y, Z, lux; magnitudes at 40 fraction bits
  localparam logic [39:0] MATRIX_MAG [4][4] = '{
    '{40'd258267576, 40'd20852501,  40'd13283385,  40'd0},
    '{40'd44801519,  40'd218756857, 40'd17465535,  40'd2363950000},
    '{40'd102102783, 40'd18663061,  40'd741094499, 40'd0},
    '{40'd0,         40'd0,         40'd0,         40'd0}
  };
  // bit j set: column j of that row is negative
  localparam logic [3:0] MATRIX_NEG [4] = '{4'b0010, 4'b0100, 4'b0010, 4'b0000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cscc_in_if  in_chan ();
  cscc_out_if out_chan ();

  color_sensor_cie_conversion u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic     drv_valid = 1'b0;
  sample_t  drv_item  = '0;
  logic     rcv_ready = 1'b0;

  assign in_chan.valid   = drv_valid;
  assign in_chan.raw_ch0 = drv_item.raw[0];
  assign in_chan.raw_ch1 = drv_item.raw[1];
  assign in_chan.raw_ch2 = drv_item.raw[2];
  assign in_chan.raw_ch3 = drv_item.raw[3];
  assign out_chan.ready  = rcv_ready;

  sample_t     pending_q [$];
  reading_t    expected_q [$];
  logic [3:0]  model_cnt;
  logic [3:0]  gen_cnt = '0;
  reading_t    next_reading;
  reading_t    got, want;
  int unsigned in_gap, out_stall;
  bit          in_burst, out_burst;
  int unsigned errors, n_checked, n_mm, n_zs, n_edge;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] coef_q(logic [39:0] m);
    return (64'(m) + (64'd1 << (COEF_DROP - 1))) >> COEF_DROP;
  endfunction

  function automatic logic [CHROMA_W-1:0] ratio_of(logic signed [127:0] v,
                                                   logic signed [127:0] s);
    logic [127:0] q;
    if (v <= 0) return '0;
    if (v >= s) q = (128'd1 << RATIO_FRAC_BITS) - 128'd1;
    else q = ({v} << RATIO_FRAC_BITS) / {s};
    if (q > 128'hFFFF) return '1;
    return q[CHROMA_W-1:0];
  endfunction

  function automatic reading_t convert_sample(sample_t smp, logic [3:0] want_cnt);
    logic signed [127:0] acc [4];
    logic signed [127:0] lin, prod, total, lux_t;
    reading_t r;
    r = '0;
    for (int j = 0; j < 4; j++) acc[j] = '0;
    for (int k = 0; k < 4; k++) begin
      lin = $signed(128'(smp.raw[k][27:8]) << smp.raw[k][31:28]);
      if (smp.raw[k][7:4] != want_cnt) r.counter_mismatch = 1'b1;
      for (int j = 0; j < 4; j++) begin
        prod = lin * $signed(128'(coef_q(MATRIX_MAG[k][j])));
        if (MATRIX_NEG[k][j]) acc[j] = acc[j] - prod;
        else acc[j] = acc[j] + prod;
      end
    end
    total = acc[0] + acc[1] + acc[2];
    if (total <= 0) begin
      r.zero_sum = 1'b1;
    end else begin
      r.chroma_x = ratio_of(acc[0], total);
      r.chroma_y = ratio_of(acc[1], total);
      r.chroma_z = ratio_of(acc[2], total);
    end
    if (acc[3] >= 0) begin
      lux_t = (acc[3] + (128'sd1 <<< (LUX_SH - 1))) >>> LUX_SH;
      if (|lux_t[127:LUX_W]) r.lux_q8 = '1;
      else r.lux_q8 = lux_t[LUX_W-1:0];
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [19:0] rand_mant();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 20'($urandom_range(1, 15));
      3: return 20'd1 << $urandom_range(0, 19);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_exp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 4'd0;
    if (r < 40) return 4'd15;
    return 4'($urandom);
  endfunction

  task automatic queue_words(sample_t s);
    gen_cnt = gen_cnt + 4'd1;
    pending_q.push_back(s);
  endtask

  // counters follow the sequence except on channels flagged in bad_mask
  task automatic queue_sample(logic [3:0][3:0] e, logic [3:0][19:0] m, logic [3:0] bad_mask);
    sample_t s;
    logic [3:0] c, nxt;
    nxt = gen_cnt + 4'd1;
    for (int k = 0; k < 4; k++) begin
      c = bad_mask[k] ? nxt + 4'($urandom_range(1, 15)) : nxt;
      s.raw[k] = {e[k], m[k], c, 4'($urandom)};
    end
    queue_words(s);
  endtask

  task automatic queue_random(int unsigned zero_pct, logic [3:0] bad_mask);
    logic [3:0][3:0]  e;
    logic [3:0][19:0] m;
    for (int k = 0; k < 4; k++) begin
      e[k] = rand_exp();
      m[k] = ($urandom_range(0, 99) < zero_pct) ? 20'd0 : rand_mant();
    end
    queue_sample(e, m, bad_mask);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      in_gap = 0;
      model_cnt = '0;
    end else begin
      if (drv_valid && in_chan.ready) begin
        model_cnt = model_cnt + 4'd1;
        next_reading = convert_sample(drv_item, model_cnt);
        expected_q.push_back(next_reading);
        if (next_reading.counter_mismatch) n_mm++;
        if (next_reading.zero_sum) n_zs++;
        if (!next_reading.zero_sum &&
            (next_reading.chroma_x == '1 || next_reading.chroma_y == '0 ||
             next_reading.chroma_z == '0 || next_reading.chroma_x == '0))
          n_edge++;
      end
      if (!drv_valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          drv_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_item  <= pending_q.pop_front();
          drv_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : idle_len();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.chroma_x         = out_chan.chroma_x;
        got.chroma_y         = out_chan.chroma_y;
        got.chroma_z         = out_chan.chroma_z;
        got.lux_q8           = out_chan.lux_q8;
        got.counter_mismatch = out_chan.counter_mismatch;
        got.zero_sum         = out_chan.zero_sum;
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got.chroma_x !== want.chroma_x) begin
            $error("chroma_x expected %0h got %0h", want.chroma_x, got.chroma_x);
            errors++;
          end
          if (got.chroma_y !== want.chroma_y) begin
            $error("chroma_y expected %0h got %0h", want.chroma_y, got.chroma_y);
            errors++;
          end
          if (got.chroma_z !== want.chroma_z) begin
            $error("chroma_z expected %0h got %0h", want.chroma_z, got.chroma_z);
            errors++;
          end
          if (got.lux_q8 !== want.lux_q8) begin
            $error("lux_q8 expected %0h got %0h", want.lux_q8, got.lux_q8);
            errors++;
          end
          if (got.counter_mismatch !== want.counter_mismatch) begin
            $error("counter_mismatch expected %0b got %0b",
                   want.counter_mismatch, got.counter_mismatch);
            errors++;
          end
          if (got.zero_sum !== want.zero_sum) begin
            $error("zero_sum expected %0b got %0b", want.zero_sum, got.zero_sum);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        if (!out_burst && $urandom_range(0, 99) < 10) out_stall = idle_len();
      end
    end
  end

  initial begin
    int unsigned r;
    // zero input, full scale, exponent extremes
    queue_sample('0, '0, '0);
    queue_sample({4{4'hF}}, {4{20'hFFFFF}}, '0);
    queue_sample({4{4'h0}}, {4{20'hFFFFF}}, '0);
    queue_sample({4{4'h0}}, {4{20'h00001}}, '0);
    // single channels lit, then mixes of channels: negative components and full-scale ratios
    queue_sample({4'h0, 4'h0, 4'h0, 4'hF}, {20'h0, 20'h0, 20'h0, 20'hFFFFF}, '0);
    queue_sample({4'h0, 4'h0, 4'hF, 4'h0}, {20'h0, 20'h0, 20'hFFFFF, 20'h0}, '0);
    queue_sample({4'h0, 4'hF, 4'h0, 4'h0}, {20'h0, 20'hFFFFF, 20'h0, 20'h0}, '0);
    queue_sample({4'hF, 4'h0, 4'h0, 4'h0}, {20'hFFFFF, 20'h0, 20'h0, 20'h0}, '0);
    queue_sample({4'h0, 4'h0, 4'h0, 4'h0}, {20'h0, 20'h0, 20'h00001, 20'h0}, '0);
    queue_sample({4'h0, 4'h0, 4'h0, 4'hF}, {20'h0, 20'h0, 20'h00001, 20'hFFFFF}, '0);
    queue_sample({4'h0, 4'h0, 4'hF, 4'h0}, {20'h0, 20'h00001, 20'hFFFFF, 20'h00001}, '0);
    // counter mismatch on each channel, then on all, then fixed raw words and in-sequence random samples
    for (int c = 0; c < 4; c++) queue_random(0, 4'b0001 << c);
    queue_random(0, 4'b1111);
    queue_words('{raw: {4{32'hFFFFFFFF}}});
    queue_words('{raw: {4{32'h00000000}}});
    queue_words('{raw: {4{32'h5A5AA5A5}}});
    for (int i = 0; i < 4; i++) queue_random(0, '0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_random(5, '0);
      else if (r < 82) queue_random(60, '0);
      else if (r < 93) queue_random(5, 4'($urandom_range(1, 15)));
      else queue_words('{raw: {$urandom, $urandom, $urandom, $urandom}});
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || drv_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("checked %0d transactions: %0d counter mismatches, %0d zero sums,",
             n_checked, n_mm, n_zs);
    $display("%0d with a ratio clipped to zero or full scale", n_edge);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d transactions outstanding", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
